>>> sv/mcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcp_pkg
// Shared types and constants for the midpoint circle point generator.
// ----------------------------------------------------------------------------
package mcp_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_DIAMETER = 128;
    localparam int DEF_COORD_BITS   = 11;

    // Fixed field widths and the beat limit
    localparam int DIA_W        = 8;
    localparam int OUT_W        = 13;
    localparam int OUT_FIELDS   = 8;
    localparam int RESULT_LIMIT = 48;
    localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture a new request and seed the iteration
        logic step;   // emit one beat and advance the iteration
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic active;    // current iteration produces a beat
        logic last;      // beat emitted by a step now is the final one
        logic out_free;  // output register can take a beat this cycle
    } t_sts;

endpackage

>>> sv/mcp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcp_ctrl
// Sequencer: accepts one request, then steps the datapath once per beat
// until the final point set has been issued.
// ----------------------------------------------------------------------------
module mcp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output mcp_pkg::t_cmd o_cmd,
    input  mcp_pkg::t_sts i_sts
);
    import mcp_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                // leave at once for a degenerate circle, else after the last beat
                if (!i_sts.active) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free && i_sts.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            ST_RUN: begin
                o_cmd.step = i_sts.active && i_sts.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

>>> sv/mcp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcp_datapath
// Iteration registers (offsets, step terms, error), the eight-way
// symmetric coordinate adders and the output beat register.
// ----------------------------------------------------------------------------
module mcp_datapath #(
    parameter int MAX_DIAMETER = mcp_pkg::DEF_MAX_DIAMETER,
    parameter int COORD_BITS   = mcp_pkg::DEF_COORD_BITS
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  mcp_pkg::t_cmd                                i_cmd,
    output mcp_pkg::t_sts                                o_sts,
    input  logic [COORD_BITS-1:0]                        i_left_x,
    input  logic [COORD_BITS-1:0]                        i_top_y,
    input  logic [mcp_pkg::DIA_W-1:0]                    i_diameter,
    input  logic                                         i_m_tready,
    output logic                                         o_m_tvalid,
    output logic [mcp_pkg::OUT_FIELDS*mcp_pkg::OUT_W-1:0] o_m_tdata,
    output logic                                         o_m_tlast
);
    import mcp_pkg::*;

    localparam int RAD_BITS = $clog2(MAX_DIAMETER / 2 + 1);
    localparam int OFS_W    = RAD_BITS + 1;
    localparam int STEP_W   = RAD_BITS + 2;
    localparam int ERR_W    = RAD_BITS + 4;
    localparam int CEN_W    = COORD_BITS + 1;
    localparam int SUM_W    = (COORD_BITS + 3 > OUT_W) ? COORD_BITS + 3 : OUT_W;

    // Iteration state
    logic signed [OFS_W-1:0]  r_x, r_y;
    logic        [STEP_W-1:0] r_dx, r_dy;
    logic signed [ERR_W-1:0]  r_err, r_dia;
    logic        [CEN_W-1:0]  r_cx, r_cy;
    logic        [CNT_W-1:0]  r_count;

    // Output beat
    logic                              r_valid;
    logic [OUT_FIELDS*OUT_W-1:0]       r_data;
    logic                              r_last;

    // Request decode
    logic [DIA_W-1:0]   dia_sat;
    logic [DIA_W-2:0]   radius;

    // Next iteration values
    logic signed [OFS_W-1:0]  x_nx, y_nx;
    logic        [STEP_W-1:0] dx_nx, dy_nx;
    logic signed [ERR_W-1:0]  err_mid, err_nx;
    logic        [CNT_W-1:0]  count_nx;
    logic                     active_nx;

    // Coordinate sums
    logic signed [SUM_W-1:0] s_cx, s_cy, s_x, s_y;
    logic signed [SUM_W-1:0] p_cxpx, p_cxmx, p_cxpy, p_cxmy;
    logic signed [SUM_W-1:0] p_cypy, p_cymy, p_cypx, p_cymx;

    // Saturate the diameter, halve for the radius
    assign dia_sat = (i_diameter > DIA_W'(MAX_DIAMETER)) ? DIA_W'(MAX_DIAMETER) : i_diameter;
    assign radius  = dia_sat[DIA_W-1:1];

    // One midpoint step: y move first, then x move on the updated error
    always_comb begin
        y_nx    = r_y;
        dy_nx   = r_dy;
        err_mid = r_err;
        if (r_err <= 0) begin
            y_nx    = r_y + OFS_W'(1);
            err_mid = r_err + signed'(ERR_W'(r_dy));
            dy_nx   = r_dy + STEP_W'(2);
        end
        x_nx   = r_x;
        dx_nx  = r_dx;
        err_nx = err_mid;
        if (err_mid > 0) begin
            x_nx   = r_x - OFS_W'(1);
            dx_nx  = r_dx + STEP_W'(2);
            err_nx = err_mid + signed'(ERR_W'(dx_nx)) - r_dia;
        end
    end

    assign count_nx  = r_count + CNT_W'(1);
    assign active_nx = (x_nx >= y_nx) && (count_nx < CNT_W'(RESULT_LIMIT));

    // Status
    assign o_sts.active   = (r_x >= r_y) && (r_count < CNT_W'(RESULT_LIMIT));
    assign o_sts.last     = !active_nx;
    assign o_sts.out_free = !r_valid || i_m_tready;

    // Eight symmetric coordinates
    assign s_cx   = signed'(SUM_W'(r_cx));
    assign s_cy   = signed'(SUM_W'(r_cy));
    assign s_x    = SUM_W'(r_x);
    assign s_y    = SUM_W'(r_y);
    assign p_cxpx = s_cx + s_x;
    assign p_cxmx = s_cx - s_x;
    assign p_cxpy = s_cx + s_y;
    assign p_cxmy = s_cx - s_y;
    assign p_cypy = s_cy + s_y;
    assign p_cymy = s_cy - s_y;
    assign p_cypx = s_cy + s_x;
    assign p_cymx = s_cy - s_x;

    // Seed on load, advance on step
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dia   <= ERR_W'(dia_sat);
            r_cx    <= CEN_W'(i_left_x) + CEN_W'(radius);
            r_cy    <= CEN_W'(i_top_y) + CEN_W'(radius);
            r_x     <= OFS_W'(radius) - OFS_W'(1);
            r_y     <= '0;
            r_dx    <= STEP_W'(1);
            r_dy    <= STEP_W'(1);
            r_err   <= ERR_W'(1) - ERR_W'(dia_sat);
            r_count <= '0;
        end else if (i_cmd.step) begin
            r_x     <= x_nx;
            r_y     <= y_nx;
            r_dx    <= dx_nx;
            r_dy    <= dy_nx;
            r_err   <= err_nx;
            r_count <= count_nx;
        end
    end

    // Output valid: set on step, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload: capture on step, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_data <= {p_cymx[OUT_W-1:0], p_cypx[OUT_W-1:0],
                       p_cymy[OUT_W-1:0], p_cypy[OUT_W-1:0],
                       p_cxmy[OUT_W-1:0], p_cxpy[OUT_W-1:0],
                       p_cxmx[OUT_W-1:0], p_cxpx[OUT_W-1:0]};
            r_last <= !active_nx;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_last;

endmodule

>>> sv/midpoint_circle_points_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_points_top
// Midpoint circle point generator: one box request in, one beat of eight
// symmetric coordinates out per iteration, final beat marked by tlast.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tdata: left_x, top_y, diameter (zero padded to bytes)
//  m_axis   | out       | tdata: 8 coordinates x 13 bits; tlast: is_last
//
//  A request is loaded from idle, then the single iteration unit emits one
//  output beat per cycle unless the output stalls: about radius/sqrt(2)+1
//  beats, at most 48; the next request is taken in the cycle right after
//  the final step.
//  Diameters 0 and 1 give no beats; the run state returns straight to idle.
//  Reset is synchronous, active low; it empties the output register.
//  Output backpressure stalls the iteration; a new request is taken while
//  the final beat still waits in the output register.
// ----------------------------------------------------------------------------
module midpoint_circle_points_top #(
    parameter int MAX_DIAMETER = mcp_pkg::DEF_MAX_DIAMETER,
    parameter int COORD_BITS   = mcp_pkg::DEF_COORD_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // left_x [COORD_BITS-1:0], top_y, diameter [7:0], zero pad
    input  logic [((2*COORD_BITS+mcp_pkg::DIA_W+7)/8)*8-1:0] s_tdata,
    input  logic s_tvalid,
    output logic s_tready,
    // centre_x_plus_x, centre_x_minus_x, centre_x_plus_y, centre_x_minus_y,
    // centre_y_plus_y, centre_y_minus_y, centre_y_plus_x, centre_y_minus_x
    output logic [mcp_pkg::OUT_FIELDS*mcp_pkg::OUT_W-1:0] m_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    output logic m_tlast
);
    import mcp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    mcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    mcp_datapath #(
        .MAX_DIAMETER (MAX_DIAMETER),
        .COORD_BITS   (COORD_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_left_x   (s_tdata[COORD_BITS-1:0]),
        .i_top_y    (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_diameter (s_tdata[2*COORD_BITS+DIA_W-1:2*COORD_BITS]),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

endmodule

>>> sv/mcp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcp_checker
// Port-level checks for the circle point generator, bound to the top level.
// ----------------------------------------------------------------------------
module mcp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_tvalid,
    input logic i_s_tready,
    input logic [mcp_pkg::OUT_FIELDS*mcp_pkg::OUT_W-1:0] i_m_tdata,
    input logic i_m_tvalid,
    input logic i_m_tready,
    input logic i_m_tlast
);
    import mcp_pkg::*;

    logic [OUT_W-1:0] sum_cx_x, sum_cx_y, sum_cy_y, sum_cy_x;

    // Each symmetric pair sums to twice the centre
    assign sum_cx_x = i_m_tdata[OUT_W-1:0] + i_m_tdata[2*OUT_W-1:OUT_W];
    assign sum_cx_y = i_m_tdata[3*OUT_W-1:2*OUT_W] + i_m_tdata[4*OUT_W-1:3*OUT_W];
    assign sum_cy_y = i_m_tdata[5*OUT_W-1:4*OUT_W] + i_m_tdata[6*OUT_W-1:5*OUT_W];
    assign sum_cy_x = i_m_tdata[7*OUT_W-1:6*OUT_W] + i_m_tdata[8*OUT_W-1:7*OUT_W];

    // Stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast))
        else $error("output beat changed while stalled");

    // Ready drops after a request is accepted
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("request accepted while previous one loads");

    // Points are symmetric about the centre x
    a_sym_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> sum_cx_x == sum_cx_y)
        else $error("x coordinates not symmetric");

    // Points are symmetric about the centre y
    a_sym_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> sum_cy_y == sum_cy_x)
        else $error("y coordinates not symmetric");

endmodule

bind midpoint_circle_points_top mcp_checker u_mcp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_tvalid),
    .i_s_tready (s_tready),
    .i_m_tdata  (m_tdata),
    .i_m_tvalid (m_tvalid),
    .i_m_tready (m_tready),
    .i_m_tlast  (m_tlast)
);
